// File: rtl/b64x_pkg.sv
package b64x_pkg;

	localparam int KEY_BYTES_DEF = 32;
	localparam int KEY_WORDS     = 4;
	localparam int KEY_WORD_W    = 64;
	localparam int CFG_IDX_W     = 8;
	localparam int CHAR_W        = 8;
	localparam int BYTE_W        = 8;
	localparam int SEXTET_W      = 6;
	localparam int IDX_W         = 5;
	localparam int PEND_W        = 3;
	localparam int ACC_W         = 2 * SEXTET_W;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1 = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2 = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3 = CFG_IDX_W'(3);

	localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
	localparam logic [CHAR_W-1:0] CH_DIGIT_0 = 8'h30;
	localparam logic [CHAR_W-1:0] CH_DIGIT_9 = 8'h39;
	localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_SLASH   = 8'h2F;

	localparam logic [CHAR_W-1:0] LOWER_OFS = 8'd26;
	localparam logic [CHAR_W-1:0] DIGIT_OFS = 8'd52;
	localparam logic [SEXTET_W-1:0] VAL_PLUS  = 6'd62;
	localparam logic [SEXTET_W-1:0] VAL_SLASH = 6'd63;

	typedef struct packed {
		logic                valid;
		logic [SEXTET_W-1:0] value;
	} sextet_t;

	// one accepted character as seen by the bit accumulator
	typedef struct packed {
		logic    en;
		logic    last;
		sextet_t sx;
	} acc_step_t;

	typedef struct packed {
		logic              have;
		logic [BYTE_W-1:0] raw;
		logic [IDX_W-1:0]  idx;
	} acc_out_t;

	function automatic sextet_t sextet_of(input logic [CHAR_W-1:0] c);
		sextet_t s;
		s.valid = 1'b1;
		s.value = '0;
		if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			s.value = SEXTET_W'(c - CH_UPPER_A);
		end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
			s.value = SEXTET_W'(c - CH_LOWER_A + LOWER_OFS);
		end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
			s.value = SEXTET_W'(c - CH_DIGIT_0 + DIGIT_OFS);
		end else if (c == CH_PLUS) begin
			s.value = VAL_PLUS;
		end else if (c == CH_SLASH) begin
			s.value = VAL_SLASH;
		end else begin
			s.valid = 1'b0;
		end
		return s;
	endfunction

endpackage

// File: rtl/b64x_bit_acc.sv
module b64x_bit_acc
	import b64x_pkg::*;
#(
	parameter int KEY_BYTES = KEY_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  acc_step_t step,
	output acc_out_t  res
);

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(KEY_BYTES - 1);

	logic [SEXTET_W-1:0] acc_q;
	logic [PEND_W-1:0]   pend_q;
	logic [IDX_W-1:0]    idx_q;

	logic [ACC_W-1:0]    acc_new;
	logic [PEND_W-1:0]   shamt;
	logic                have;

	assign acc_new = {acc_q, step.sx.value};
	// a byte completes when at least two old bits wait
	assign have    = step.sx.valid && (pend_q >= PEND_W'(2));
	assign shamt   = pend_q - PEND_W'(2);

	assign res.have = have;
	assign res.raw  = BYTE_W'(acc_new >> shamt);
	assign res.idx  = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			pend_q <= '0;
			idx_q  <= '0;
		end else if (step.en) begin
			if (step.last) begin
				acc_q  <= '0;
				pend_q <= '0;
				idx_q  <= '0;
			end else if (step.sx.valid) begin
				acc_q <= step.sx.value;
				if (have) begin
					pend_q <= pend_q - PEND_W'(2);
					idx_q  <= (idx_q == IDX_LAST) ? '0 : idx_q + IDX_W'(1);
				end else begin
					pend_q <= pend_q + PEND_W'(SEXTET_W);
				end
			end
		end
	end

	a_pend_even: assert property (@(posedge clk) disable iff (!arst_n)
		!pend_q[0] && pend_q <= PEND_W'(SEXTET_W))
		else $error("pending bit count out of range");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IDX_LAST)
		else $error("byte index beyond key length");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step.en && step.last |=> pend_q == '0 && idx_q == '0)
		else $error("end of message did not clear state");

endmodule

// File: rtl/base64_repeating_key_xor_decrypt_core.sv
// Decodes a Base64 character stream and removes a repeating-key XOR, one
// character per clock when no held result stalls it: a character beat can
// be taken every cycle while out_ready drains results, and each decoded
// byte passes the input register, then the result register. Characters
// outside A-Z a-z 0-9 + / (padding too) are dropped and give no result
// unless last_char is set; last_char always gives one result with
// message_end, carrying a byte when one completed, and then restarts bit
// gathering and the key position. The key is four 64-bit little-endian
// words for the user to write via cfg_we/cfg_index/cfg_data only while the
// stream is idle (not enforced); byte n uses key byte (n mod KEY_BYTES).
module base64_repeating_key_xor_decrypt_core
	import b64x_pkg::*;
#(
	parameter int KEY_BYTES = KEY_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [KEY_WORD_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [CHAR_W-1:0]     in_char,
	input  logic                  last_char,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [BYTE_W-1:0]     plain_byte,
	output logic                  byte_valid,
	output logic                  message_end
);

	logic [KEY_WORD_W-1:0] key_q [KEY_WORDS];

	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;

	logic              out_valid_q;
	logic [BYTE_W-1:0] byte_q;
	logic              bvalid_q;
	logic              end_q;

	acc_step_t         step;
	acc_out_t          acc;
	logic [BYTE_W-1:0] key_byte;
	logic              produce;
	logic              out_free;
	logic              adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEY_WORDS; i++) begin
				key_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_WORD_0: key_q[0] <= cfg_data;
				REG_KEY_WORD_1: key_q[1] <= cfg_data;
				REG_KEY_WORD_2: key_q[2] <= cfg_data;
				REG_KEY_WORD_3: key_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign step.en   = adv_s1;
	assign step.last = last_s1;
	assign step.sx   = sextet_of(char_s1);

	b64x_bit_acc #(
		.KEY_BYTES(KEY_BYTES)
	) u_bit_acc (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (step),
		.res   (acc)
	);

	assign key_byte = BYTE_W'(key_q[acc.idx[IDX_W-1:3]] >> {acc.idx[2:0], 3'b000});

	// a dropped character without the end mark moves on without a result
	assign produce  = acc.have || last_s1;
	assign out_free = !out_valid_q || out_ready;
	assign adv_s1   = valid_s1 && (out_free || !produce);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= in_char;
			last_s1 <= last_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && produce) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && produce) begin
			byte_q   <= acc.have ? (acc.raw ^ key_byte) : '0;
			bvalid_q <= acc.have;
			end_q    <= last_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign plain_byte  = byte_q;
	assign byte_valid  = bvalid_q;
	assign message_end = end_q;

	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> bvalid_q || end_q)
		else $error("result beat carries neither byte nor end mark");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !bvalid_q |-> byte_q == '0)
		else $error("empty result carries a nonzero byte");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && produce |-> out_free)
		else $error("result register overwritten while held");

endmodule
